>>> hw/rtl/pdc_pkg.sv
// Shared types, widths and constants for the pad digit coalescer.
package pdc_pkg;

  localparam int DET_W = 11;
  localparam int PAD_W = 16;
  localparam int ADC_W = 32;
  localparam int SMP_W = 10;
  localparam int KEY_W = DET_W + PAD_W;

  localparam int MAX_DIGITS_DEF = 64;

  localparam logic [SMP_W-1:0] SAMPLES_MAX = 10'h3FF;

  localparam logic KIND_DIGIT = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef struct packed {
    logic [DET_W-1:0] det_id;
    logic [PAD_W-1:0] pad_id;
    logic [ADC_W-1:0] adc;
    logic [SMP_W-1:0] samples;
    logic             saturated;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap_in;
    logic find;
    logic rd_hit;
    logic insert;
    logic drop;
    logic merge;
    logic rd_emit;
    logic emit_load;
    logic emit_empty;
    logic clear_event;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic full;
    logic empty;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

>>> hw/rtl/pdc_datapath.sv
// Datapath: key match, entry storage, merge arithmetic and result register.
module pdc_datapath #(
  parameter int MAX_DIGITS = pdc_pkg::MAX_DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  pdc_pkg::cmd_t              cmd,
  output pdc_pkg::sts_t              sts,
  input  logic [pdc_pkg::DET_W-1:0]  det_id,
  input  logic [pdc_pkg::PAD_W-1:0]  pad_id,
  input  logic [pdc_pkg::ADC_W-1:0]  adc,
  input  logic [pdc_pkg::SMP_W-1:0]  nof_samples,
  input  logic                       saturated,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pdc_pkg::DET_W-1:0]  out_det_id,
  output logic [pdc_pkg::PAD_W-1:0]  out_pad_id,
  output logic [pdc_pkg::ADC_W-1:0]  out_adc,
  output logic [pdc_pkg::SMP_W-1:0]  out_samples,
  output logic                       out_saturated,
  output logic                       last,
  output logic                       empty_event,
  output logic                       overflow
);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  pdc_pkg::entry_t                 in_word;
  logic [pdc_pkg::KEY_W-1:0]       key_arr [MAX_DIGITS];
  pdc_pkg::entry_t                 mem [MAX_DIGITS];
  pdc_pkg::entry_t                 rd_data;
  pdc_pkg::entry_t                 merged;
  logic [CNT_W-1:0]                count;
  logic                            dropped;
  logic [IDX_W-1:0]                emit_idx;
  logic                            hit;
  logic [IDX_W-1:0]                hit_idx;
  logic                            hit_c;
  logic [IDX_W-1:0]                hit_idx_c;
  logic [pdc_pkg::KEY_W-1:0]       in_key;
  logic [pdc_pkg::SMP_W:0]         smp_sum;
  logic                            wr_en;
  logic [IDX_W-1:0]                wr_addr;
  pdc_pkg::entry_t                 wr_data;
  logic                            rd_en;
  logic [IDX_W-1:0]                rd_addr;

  assign in_key = {in_word.det_id, in_word.pad_id};

  // Keys stored in the table are unique, so at most one entry matches and the
  // index can be built by OR-ing the indexes of matching entries.
  always_comb begin
    hit_c     = 1'b0;
    hit_idx_c = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if ((CNT_W'(i) < count) && (key_arr[i] == in_key)) begin
        hit_c     = 1'b1;
        hit_idx_c = hit_idx_c | IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      in_word.det_id    <= det_id;
      in_word.pad_id    <= pad_id;
      in_word.adc       <= adc;
      in_word.samples   <= nof_samples;
      in_word.saturated <= saturated;
    end
    if (cmd.find) begin
      hit     <= hit_c;
      hit_idx <= hit_idx_c;
    end
    if (cmd.insert) begin
      key_arr[count[IDX_W-1:0]] <= in_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      dropped  <= 1'b0;
      emit_idx <= '0;
    end else begin
      if (cmd.clear_event) begin
        count    <= '0;
        dropped  <= 1'b0;
        emit_idx <= '0;
      end else begin
        if (cmd.insert) begin
          count <= count + CNT_W'(1);
        end
        if (cmd.drop) begin
          dropped <= 1'b1;
        end
        if (cmd.emit_load) begin
          emit_idx <= emit_idx + IDX_W'(1);
        end
      end
    end
  end

  // Merge of a repeated key into the stored entry.
  assign smp_sum = {1'b0, rd_data.samples} + {1'b0, in_word.samples};

  always_comb begin
    merged           = rd_data;
    merged.adc       = rd_data.adc + in_word.adc;
    merged.samples   = smp_sum[pdc_pkg::SMP_W] ? pdc_pkg::SAMPLES_MAX
                                               : smp_sum[pdc_pkg::SMP_W-1:0];
    merged.saturated = rd_data.saturated | in_word.saturated;
  end

  assign wr_en   = cmd.insert | cmd.merge;
  assign wr_addr = cmd.merge ? hit_idx : count[IDX_W-1:0];
  assign wr_data = cmd.merge ? merged : in_word;
  assign rd_en   = cmd.rd_hit | cmd.rd_emit;
  assign rd_addr = cmd.rd_hit ? hit_idx : emit_idx;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load || cmd.emit_empty) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_det_id    <= rd_data.det_id;
      out_pad_id    <= rd_data.pad_id;
      out_adc       <= rd_data.adc;
      out_samples   <= rd_data.samples;
      out_saturated <= rd_data.saturated;
      last          <= sts.emit_last;
      empty_event   <= 1'b0;
      overflow      <= dropped;
    end else if (cmd.emit_empty) begin
      out_det_id    <= '0;
      out_pad_id    <= '0;
      out_adc       <= '0;
      out_samples   <= '0;
      out_saturated <= 1'b0;
      last          <= 1'b1;
      empty_event   <= 1'b1;
      overflow      <= 1'b0;
    end
  end

  assign sts.hit       = hit;
  assign sts.full      = (count == CNT_W'(MAX_DIGITS));
  assign sts.empty     = (count == '0);
  assign sts.emit_last = (CNT_W'(emit_idx) == (count - CNT_W'(1)));
  assign sts.out_free  = !out_valid || !out_stall;

  a_insert_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !sts.full)
    else $error("entry inserted into a full table");

  a_merge_after_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.merge |-> hit)
    else $error("merge issued without a key match");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_DIGITS))
    else $error("entry count beyond table capacity");

  a_no_load_over_held: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_load || cmd.emit_empty) |-> sts.out_free)
    else $error("result loaded over a word still waiting");

endmodule

>>> hw/rtl/pdc_ctrl.sv
// Controller state machine: sequences match, merge and result emission.
module pdc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          kind,
  input  pdc_pkg::sts_t sts,
  output pdc_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_UPDATE,
    S_MERGE,
    S_EMIT_RD,
    S_EMIT_OUT,
    S_EMPTY
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.cap_in = 1'b1;
          if (kind == pdc_pkg::KIND_DIGIT) begin
            state_next = S_FIND;
          end else if (sts.empty) begin
            state_next = S_EMPTY;
          end else begin
            state_next = S_EMIT_RD;
          end
        end
      end
      S_FIND: begin
        cmd.find   = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (sts.hit) begin
          cmd.rd_hit = 1'b1;
          state_next = S_MERGE;
        end else begin
          if (sts.full) begin
            cmd.drop = 1'b1;
          end else begin
            cmd.insert = 1'b1;
          end
          state_next = S_IDLE;
        end
      end
      S_MERGE: begin
        cmd.merge  = 1'b1;
        state_next = S_IDLE;
      end
      S_EMIT_RD: begin
        cmd.rd_emit = 1'b1;
        state_next  = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          if (sts.emit_last) begin
            cmd.clear_event = 1'b1;
            state_next      = S_IDLE;
          end else begin
            state_next = S_EMIT_RD;
          end
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          cmd.emit_empty  = 1'b1;
          cmd.clear_event = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // The input is held off for as long as an item is still being worked on.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_stall <= 1'b0;
    end else begin
      state    <= state_next;
      in_stall <= (state_next != S_IDLE);
    end
  end

  a_stall_tracks_busy: assert property (@(posedge clk) disable iff (rst)
    in_stall == (state != S_IDLE))
    else $error("input stall out of step with controller state");

  a_merge_follows_read: assert property (@(posedge clk) disable iff (rst)
    cmd.merge |-> $past(cmd.rd_hit))
    else $error("merge without a preceding entry read");

  a_emit_follows_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_OUT && $past(state) != S_EMIT_OUT) |-> $past(cmd.rd_emit))
    else $error("result load entered without an entry read");

endmodule

>>> hw/rtl/pad_digit_coalescer_core.sv
// Top level of the pad digit coalescer: controller plus datapath.
// A digit word steps through find and update, then a merge state when its key
// matches a stored entry; the key match over all entries is one parallel compare.
// An end-of-event word emits each stored digit in turn (entry read, then result
// load through the single read port), or one empty-event word for an empty event.
// Reset (rst, synchronous) empties the table and clears the overflow mark.
module pad_digit_coalescer_core #(
  parameter int MAX_DIGITS = pdc_pkg::MAX_DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       kind,
  input  logic [pdc_pkg::DET_W-1:0]  det_id,
  input  logic [pdc_pkg::PAD_W-1:0]  pad_id,
  input  logic [pdc_pkg::ADC_W-1:0]  adc,
  input  logic [pdc_pkg::SMP_W-1:0]  nof_samples,
  input  logic                       saturated,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pdc_pkg::DET_W-1:0]  out_det_id,
  output logic [pdc_pkg::PAD_W-1:0]  out_pad_id,
  output logic [pdc_pkg::ADC_W-1:0]  out_adc,
  output logic [pdc_pkg::SMP_W-1:0]  out_samples,
  output logic                       out_saturated,
  output logic                       last,
  output logic                       empty_event,
  output logic                       overflow
);

  pdc_pkg::cmd_t cmd;
  pdc_pkg::sts_t sts;

  pdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .sts      (sts),
    .cmd      (cmd)
  );

  pdc_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .det_id        (det_id),
    .pad_id        (pad_id),
    .adc           (adc),
    .nof_samples   (nof_samples),
    .saturated     (saturated),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_det_id    (out_det_id),
    .out_pad_id    (out_pad_id),
    .out_adc       (out_adc),
    .out_samples   (out_samples),
    .out_saturated (out_saturated),
    .last          (last),
    .empty_event   (empty_event),
    .overflow      (overflow)
  );

endmodule

>>> sim/pad_digit_coalescer_core_tb.sv
// Self-checking testbench for the pad digit coalescer core.
module pad_digit_coalescer_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DET_W        = pdc_pkg::DET_W;
  localparam int PAD_W        = pdc_pkg::PAD_W;
  localparam int ADC_W        = pdc_pkg::ADC_W;
  localparam int SMP_W        = pdc_pkg::SMP_W;
  localparam int KEY_W        = pdc_pkg::KEY_W;
  localparam int TABLE_SIZE   = pdc_pkg::MAX_DIGITS_DEF;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic [DET_W-1:0] det_id;
    logic [PAD_W-1:0] pad_id;
    logic [ADC_W-1:0] adc;
    logic [SMP_W-1:0] samples;
    logic             saturated;
    logic             last;
    logic             empty_event;
    logic             overflow;
  } merged_digit_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic             kind;
  logic [DET_W-1:0] det_id;
  logic [PAD_W-1:0] pad_id;
  logic [ADC_W-1:0] adc;
  logic [SMP_W-1:0] nof_samples;
  logic             saturated;
  logic             out_valid;
  logic             out_stall;
  logic [DET_W-1:0] out_det_id;
  logic [PAD_W-1:0] out_pad_id;
  logic [ADC_W-1:0] out_adc;
  logic [SMP_W-1:0] out_samples;
  logic             out_saturated;
  logic             last;
  logic             empty_event;
  logic             overflow;

  // Predicted contents of the coalescing table for the open event.
  logic [KEY_W-1:0] stored_key     [TABLE_SIZE];
  logic [ADC_W-1:0] stored_adc     [TABLE_SIZE];
  logic [SMP_W-1:0] stored_samples [TABLE_SIZE];
  logic             stored_sat     [TABLE_SIZE];
  int               stored_count;
  logic             key_dropped;

  merged_digit_t pending_digits[$];
  int            mismatches;
  int            cycle_count;
  int            random_words;
  bit            calm;
  bit            hold_req;

  pad_digit_coalescer_core uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .det_id       (det_id),
    .pad_id       (pad_id),
    .adc          (adc),
    .nof_samples  (nof_samples),
    .saturated    (saturated),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_det_id   (out_det_id),
    .out_pad_id   (out_pad_id),
    .out_adc      (out_adc),
    .out_samples  (out_samples),
    .out_saturated(out_saturated),
    .last         (last),
    .empty_event  (empty_event),
    .overflow     (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[pad_digit_coalescer_core] ERROR");
      $finish;
    end
  end

  // Mostly back to back, sometimes a short gap, rarely a long pause.
  function automatic int idle_length();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void merge_digit(logic [DET_W-1:0] d, logic [PAD_W-1:0] p,
                                      logic [ADC_W-1:0] a, logic [SMP_W-1:0] n,
                                      logic s);
    logic [KEY_W-1:0] key;
    logic [SMP_W:0]   sum;
    key = {d, p};
    for (int i = 0; i < stored_count; i++) begin
      if (stored_key[i] == key) begin
        stored_adc[i] = stored_adc[i] + a;
        sum = {1'b0, stored_samples[i]} + {1'b0, n};
        stored_samples[i] = (sum > pdc_pkg::SAMPLES_MAX) ? pdc_pkg::SAMPLES_MAX
                                                         : sum[SMP_W-1:0];
        stored_sat[i] = stored_sat[i] | s;
        return;
      end
    end
    if (stored_count < TABLE_SIZE) begin
      stored_key[stored_count]     = key;
      stored_adc[stored_count]     = a;
      stored_samples[stored_count] = n;
      stored_sat[stored_count]     = s;
      stored_count++;
    end else begin
      key_dropped = 1'b1;
    end
  endfunction

  function automatic void close_event();
    merged_digit_t m;
    if (stored_count == 0) begin
      m = '{default: '0};
      m.last        = 1'b1;
      m.empty_event = 1'b1;
      pending_digits = {pending_digits, m};
    end
    for (int i = 0; i < stored_count; i++) begin
      m.det_id      = stored_key[i][KEY_W-1:PAD_W];
      m.pad_id      = stored_key[i][PAD_W-1:0];
      m.adc         = stored_adc[i];
      m.samples     = stored_samples[i];
      m.saturated   = stored_sat[i];
      m.last        = (i == stored_count - 1);
      m.empty_event = 1'b0;
      m.overflow    = key_dropped;
      pending_digits = {pending_digits, m};
    end
    stored_count = 0;
    key_dropped  = 1'b0;
  endfunction

  // Offers one word and returns at the edge that accepts it. Handshake
  // signals are sampled at the falling edge, where nothing is changing.
  task automatic send_word(logic k, logic [DET_W-1:0] d, logic [PAD_W-1:0] p,
                           logic [ADC_W-1:0] a, logic [SMP_W-1:0] n, logic s);
    int gap;
    gap = idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    det_id      <= d;
    pad_id      <= p;
    adc         <= a;
    nof_samples <= n;
    saturated   <= s;
    do @(negedge clk); while (in_stall !== 1'b0);
    @(posedge clk);
    if (k == pdc_pkg::KIND_DIGIT) merge_digit(d, p, a, n, s);
    else close_event();
  endtask

  task automatic send_digit(logic [DET_W-1:0] d, logic [PAD_W-1:0] p,
                            logic [ADC_W-1:0] a, logic [SMP_W-1:0] n, logic s);
    send_word(pdc_pkg::KIND_DIGIT, d, p, a, n, s);
  endtask

  // The payload of an end-of-event word carries no meaning, so it is random.
  task automatic send_end();
    send_word(pdc_pkg::KIND_END, DET_W'($urandom), PAD_W'($urandom), $urandom,
              SMP_W'($urandom), 1'($urandom));
  endtask

  // Output stall: random stretches, plus one long hold-off on request.
  initial begin
    int stall_left;
    int run_left;
    int hold_left;
    stall_left = 0;
    run_left   = 0;
    hold_left  = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (run_left > 0) begin
          run_left--;
        end else begin
          stall_left = idle_length();
          run_left   = $urandom_range(1, 12);
        end
      end
    end
  end

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(negedge clk) begin
    merged_digit_t m;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_digits.size() == 0) begin
        $error("result word with no merged digit pending");
        mismatches++;
      end else begin
        m = pending_digits.pop_front();
        check_field("out_det_id", m.det_id, out_det_id);
        check_field("out_pad_id", m.pad_id, out_pad_id);
        check_field("out_adc", m.adc, out_adc);
        check_field("out_samples", m.samples, out_samples);
        check_field("out_saturated", m.saturated, out_saturated);
        check_field("last", m.last, last);
        check_field("empty_event", m.empty_event, empty_event);
        check_field("overflow", m.overflow, overflow);
      end
    end
  end

  task automatic test_empty_event();
    send_end();
  endtask

  task automatic test_field_extremes();
    send_digit('0, '0, '0, '0, 1'b0);
    send_digit('1, '1, '1, '1, 1'b1);
    send_digit('1, '0, 32'h0000_0001, 10'h001, 1'b0);
    send_digit('0, '1, 32'h8000_0000, 10'h200, 1'b1);
    send_digit(11'h555, 16'hAAAA, 32'h5555_AAAA, 10'h2AA, 1'b0);
    send_digit(11'h2AA, 16'h5555, 32'hAAAA_5555, 10'h155, 1'b1);
    send_end();
  endtask

  // ADC wrap, sample saturation and flag OR on a repeated key; keys that
  // share only the detector or only the pad stay separate.
  task automatic test_merging();
    send_digit(11'd100, 16'd7, 32'hFFFF_FFF0, 10'd1000, 1'b0);
    send_digit(11'd100, 16'd8, 32'd5, 10'd3, 1'b0);
    send_digit(11'd100, 16'd7, 32'h0000_0020, 10'd100, 1'b1);
    send_digit(11'd101, 16'd7, 32'd9, 10'd4, 1'b0);
    send_digit(11'd100, 16'd7, 32'd1, 10'd1023, 1'b0);
    send_digit(11'd100, 16'd8, 32'hFFFF_FFFF, 10'd1020, 1'b0);
    send_digit(11'd100, 16'd8, 32'd1, 10'd3, 1'b0);
    send_end();
    send_end();
  endtask

  // Fill all entries, drop two new keys, still merge a stored one, then
  // check that the overflow mark does not leak into the next events.
  task automatic test_table_full();
    logic [DET_W-1:0] d;
    d = DET_W'($urandom);
    for (int i = 0; i < TABLE_SIZE; i++)
      send_digit(d, PAD_W'(i), $urandom, SMP_W'($urandom), 1'($urandom));
    send_digit(d, PAD_W'(TABLE_SIZE), $urandom, SMP_W'($urandom), 1'b1);
    send_digit(d, 16'd3, $urandom, SMP_W'($urandom), 1'b1);
    send_digit(d + 11'd1, 16'd3, $urandom, SMP_W'($urandom), 1'b0);
    send_end();
    send_digit(d, 16'd3, 32'd1, 10'd1, 1'b0);
    send_end();
    send_end();
  endtask

  // Events with random content. Keys come from a pool no larger than the digit
  // count so that they can repeat; occasionally an event overruns the table.
  task automatic send_random_event(bit big);
    logic [DET_W-1:0] pool_det[];
    logic [PAD_W-1:0] pool_pad[];
    int digits;
    int keys;
    int pick;
    if (big) begin
      digits = $urandom_range(TABLE_SIZE + 1, TABLE_SIZE + 12);
      keys   = $urandom_range(TABLE_SIZE + 1, digits);
    end else begin
      digits = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
      keys   = $urandom_range(1, (digits > 0) ? digits : 1);
    end
    pool_det = new[keys];
    pool_pad = new[keys];
    for (int i = 0; i < keys; i++) begin
      pool_det[i] = DET_W'($urandom);
      pool_pad[i] = PAD_W'($urandom);
    end
    for (int i = 0; i < digits; i++) begin
      pick = big ? (i % keys) : $urandom_range(0, keys - 1);
      send_digit(pool_det[pick], pool_pad[pick], $urandom, SMP_W'($urandom),
                 1'($urandom));
      random_words++;
    end
    send_end();
    random_words++;
  endtask

  // The receiver holds off while whole events keep arriving, so the block
  // has to stall its input.
  task automatic test_receiver_holdoff();
    hold_req = 1'b1;
    calm     = 1'b1;
    for (int e = 0; e < 3; e++) begin
      for (int i = 0; i < 8; i++)
        send_digit(DET_W'($urandom), PAD_W'(i), $urandom, SMP_W'($urandom),
                   1'($urandom));
      send_end();
    end
    calm = 1'b0;
  endtask

  task automatic test_random_events();
    int events;
    events = 0;
    while (random_words < 200) begin
      calm = ($urandom_range(0, 5) == 0);
      send_random_event(events == 5 || events == 30);
      events++;
    end
    calm = 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    kind         = pdc_pkg::KIND_DIGIT;
    det_id       = '0;
    pad_id       = '0;
    adc          = '0;
    nof_samples  = '0;
    saturated    = 1'b0;
    stored_count = 0;
    key_dropped  = 1'b0;
    mismatches   = 0;
    cycle_count  = 0;
    random_words = 0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_event();
    test_field_extremes();
    test_merging();
    test_table_full();
    test_receiver_holdoff();
    test_random_events();
    in_valid <= 1'b0;

    while (pending_digits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[pad_digit_coalescer_core] OK");
    end else begin
      $display("[pad_digit_coalescer_core] ERROR");
    end
    $finish;
  end

endmodule
